@@ hw/rtl/dfrem_pkg.sv @@
package dfrem_pkg;

  localparam int unsigned SigW = 53;
  localparam int unsigned ExpW = 13;
  localparam int unsigned QDepth = 2;

  localparam logic [63:0] QNanBits = 64'h7FF8_0000_0000_0000;
  localparam logic [62:0] InfMag = 63'h7FF0_0000_0000_0000;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DOMAIN  = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef struct packed {
    logic [63:0] dividend_bits;
    logic [63:0] divisor_bits;
  } in_item_t;

  typedef struct packed {
    logic [63:0] remainder_bits;
    logic [1:0]  status;
  } out_item_t;

  // Classified work handed from the front end to the reduction engine.
  typedef struct packed {
    logic                   done;
    out_item_t              early;
    logic                   sign;
    logic [SigW-1:0]        mx;
    logic [SigW-1:0]        my;
    logic signed [ExpW-1:0] ey;
    logic [11:0]            steps;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM_X,
    S_NORM_Y,
    S_EMIT
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_REDUCE,
    B_FINAL,
    B_NORM,
    B_PACK,
    B_OUT
  } back_state_e;

endpackage

@@ hw/rtl/dfrem_front.sv @@
module dfrem_front
  import dfrem_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     job_valid_o,
  input  logic     job_ready_i,
  output job_t     job_o
);

  front_state_e state_q, state_d;
  logic [SigW-1:0] mx_q, mx_d, my_q, my_d;
  logic signed [ExpW-1:0] ex_q, ex_d, ey_q, ey_d;
  logic sign_q, sign_d;
  logic done_q, done_d;
  out_item_t early_q, early_d;
  logic [62:0] ax, ay;
  logic signed [ExpW-1:0] diff;

  assign ax = in_data_i.dividend_bits[62:0];
  assign ay = in_data_i.divisor_bits[62:0];
  assign diff = ex_q - ey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q    <= mx_d;
    my_q    <= my_d;
    ex_q    <= ex_d;
    ey_q    <= ey_d;
    sign_q  <= sign_d;
    done_q  <= done_d;
    early_q <= early_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_NORM_X;
      S_NORM_X: if (mx_q[SigW-1]) state_d = S_NORM_Y;
      S_NORM_Y: if (my_q[SigW-1]) state_d = S_EMIT;
      S_EMIT:   if (job_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mx_d = mx_q;
    my_d = my_q;
    ex_d = ex_q;
    ey_d = ey_q;
    sign_d = sign_q;
    done_d = done_q;
    early_d = early_q;
    in_ready_o = 1'b0;
    job_valid_o = 1'b0;
    job_o = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        sign_d = in_data_i.dividend_bits[63];
        mx_d = {(ax[62:52] != 11'd0), ax[51:0]};
        my_d = {(ay[62:52] != 11'd0), ay[51:0]};
        ex_d = (ax[62:52] == 11'd0) ? ExpW'(1) : ExpW'({2'b00, ax[62:52]});
        ey_d = (ay[62:52] == 11'd0) ? ExpW'(1) : ExpW'({2'b00, ay[62:52]});
        done_d = 1'b1;
        early_d.status = ST_OK;
        early_d.remainder_bits = in_data_i.dividend_bits;
        if (ay == 63'd0) begin
          early_d.status = ST_DOMAIN;
        end else if (ax >= InfMag || ay > InfMag) begin
          early_d.status = ST_INVALID;
          early_d.remainder_bits = QNanBits;
        end else if (ax < ay) begin
        end else if (ax == ay) begin
          early_d.remainder_bits = {in_data_i.dividend_bits[63], 63'd0};
        end else begin
          done_d = 1'b0;
        end
        if (done_d) begin
          mx_d[SigW-1] = 1'b1;
          my_d[SigW-1] = 1'b1;
        end
      end
      S_NORM_X: if (!mx_q[SigW-1]) begin
        mx_d = mx_q << 1;
        ex_d = ex_q - ExpW'(1);
      end
      S_NORM_Y: if (!my_q[SigW-1]) begin
        my_d = my_q << 1;
        ey_d = ey_q - ExpW'(1);
      end
      S_EMIT: begin
        job_valid_o = 1'b1;
        job_o.done = done_q;
        job_o.early = early_q;
        job_o.sign = sign_q;
        job_o.mx = mx_q;
        job_o.my = my_q;
        job_o.ey = ey_q;
        job_o.steps = diff[11:0];
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/dfrem_queue.sv @@
module dfrem_queue
  import dfrem_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_data_o
);

  job_t mem_q [QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != 2'(QDepth));
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

@@ hw/rtl/dfrem_back.sv @@
module dfrem_back
  import dfrem_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  job_t      job_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  back_state_e state_q, state_d;
  logic [SigW:0] mx_q, mx_d;
  logic [SigW-1:0] my_q, my_d;
  logic signed [ExpW-1:0] ey_q, ey_d;
  logic [11:0] n_q, n_d;
  logic sign_q, sign_d;
  out_item_t res_q, res_d;
  logic [SigW:0] dif;
  logic ge;
  logic signed [ExpW-1:0] sh;
  logic [63:0] sub;

  assign ge = mx_q >= {1'b0, my_q};
  assign dif = mx_q - {1'b0, my_q};
  assign sh = ExpW'(1) - ey_q;
  assign sub = (sh >= ExpW'(64)) ? 64'd0 : (64'(mx_q[SigW-1:0]) >> sh[5:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q <= mx_d;
    my_q <= my_d;
    ey_q <= ey_d;
    n_q <= n_d;
    sign_q <= sign_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:   if (job_valid_i) state_d = job_i.done ? B_OUT : B_REDUCE;
      B_REDUCE: if (n_q == 12'd0) state_d = B_FINAL;
                else if (ge && dif == '0) state_d = B_OUT;
      B_FINAL:  state_d = (ge ? dif == '0 : mx_q == '0) ? B_OUT : B_NORM;
      B_NORM:   if (mx_q[SigW-1]) state_d = B_PACK;
      B_PACK:   state_d = B_OUT;
      B_OUT:    if (out_ready_i) state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  always_comb begin
    mx_d = mx_q;
    my_d = my_q;
    ey_d = ey_q;
    n_d = n_q;
    sign_d = sign_q;
    res_d = res_q;
    job_ready_o = 1'b0;
    out_valid_o = 1'b0;
    out_data_o = res_q;
    case (state_q)
      B_IDLE: begin
        job_ready_o = 1'b1;
        mx_d = {1'b0, job_i.mx};
        my_d = job_i.my;
        ey_d = job_i.ey;
        n_d = job_i.steps;
        sign_d = job_i.sign;
        res_d = job_i.early;
      end
      B_REDUCE: begin
        res_d.status = ST_OK;
        res_d.remainder_bits = {sign_q, 63'd0};
        if (n_q != 12'd0) begin
          mx_d = ge ? {dif[SigW-1:0], 1'b0} : {mx_q[SigW-1:0], 1'b0};
          n_d = n_q - 12'd1;
        end
      end
      B_FINAL: if (ge) mx_d = dif;
      B_NORM: if (!mx_q[SigW-1]) begin
        mx_d = mx_q << 1;
        ey_d = ey_q - ExpW'(1);
      end
      B_PACK: begin
        if (ey_q >= ExpW'(1)) begin
          res_d.remainder_bits = {sign_q, ey_q[10:0], mx_q[51:0]};
        end else begin
          res_d.remainder_bits = {sign_q, sub[62:0]};
        end
      end
      B_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/double_float_remainder_top.sv @@
// Processing time is set by subnormal normalization in the front end
// and by one shift-subtract reduction step per unit of exponent difference in the back end.
// Throughput: the back end takes one transaction at a time; the front end classifies the next
// transaction while the back end reduces, through a two-entry queue.
// Reset: asynchronous, active low; clears all control state, no transaction in flight.
module double_float_remainder_top
  import dfrem_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  dfrem_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  dfrem_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_job),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_data_o(b_job)
  );

  dfrem_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(b_valid), .job_ready_o(b_ready), .job_i(b_job),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
